FILE: rtl/lzmd_pkg.sv
package lzmd_pkg;

    // window positions are tracked on 16 bits, enough for the widest mask
    localparam int POS_W = 16;
    // copy length counter width, covers the largest allowed run of 64
    localparam int LEN_W = 7;
    localparam int WL_W  = 4;

    typedef enum logic [1:0]
    {
        CMD_NONE,
        CMD_LIT,
        CMD_COPY,
        CMD_ERR
    } cmd_kind_t;

    typedef struct packed
    {
        cmd_kind_t          kind;
        logic [7:0]         lit;
        logic [LEN_W-1:0]   len;
        logic [POS_W-1:0]   distance;
    } cmd_t;

    function automatic logic [POS_W-1:0] slot_mask(input logic [WL_W-1:0] wl);
        return (POS_W'(1) << wl) - POS_W'(1);
    endfunction

endpackage

FILE: rtl/lzmd_window_ram.sv
module lzmd_window_ram #(
    parameter int ADDR_W = 13
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [7:0]        wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [7:0]        rd_data
);

    logic [7:0] mem [2**ADDR_W];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read data holds until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/lzmd_token_parser.sv
module lzmd_token_parser #(
    parameter int MAX_RUN = 64
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           accept,
    input  logic [7:0]     byte_in,
    input  logic           last_byte,
    output lzmd_pkg::cmd_t cmd
);

    typedef enum logic [2:0]
    {
        PH_MARKER,
        PH_SYMBOL,
        PH_AFTER,
        PH_LENGTH,
        PH_OFFSET
    } phase_t;

    phase_t                       phase_reg, phase_next;
    logic [7:0]                   marker_reg, marker_next;
    logic [31:0]                  len_reg, len_next;
    logic [lzmd_pkg::POS_W-1:0]   off_reg, off_next;
    logic [lzmd_pkg::POS_W-1:0]   off_shift;

    // only the low bits of the offset ever reach the window index
    assign off_shift = {off_reg[lzmd_pkg::POS_W-8:0], byte_in[6:0]};

    always_comb
    begin
        phase_next  = phase_reg;
        marker_next = marker_reg;
        len_next    = len_reg;
        off_next    = off_reg;
        cmd         = '0;
        cmd.kind    = lzmd_pkg::CMD_NONE;
        unique case (phase_reg)
            PH_MARKER:
            begin
                marker_next = byte_in;
                phase_next  = PH_SYMBOL;
            end
            PH_SYMBOL:
            begin
                if (byte_in == marker_reg)
                begin
                    phase_next = PH_AFTER;
                end
                else
                begin
                    cmd.kind = lzmd_pkg::CMD_LIT;
                    cmd.lit  = byte_in;
                end
            end
            PH_AFTER:
            begin
                if (byte_in == 8'd0)
                begin
                    cmd.kind   = lzmd_pkg::CMD_LIT;
                    cmd.lit    = marker_reg;
                    phase_next = PH_SYMBOL;
                end
                else
                begin
                    len_next   = {25'd0, byte_in[6:0]};
                    off_next   = '0;
                    phase_next = byte_in[7] ? PH_LENGTH : PH_OFFSET;
                end
            end
            PH_LENGTH:
            begin
                len_next = {len_reg[24:0], byte_in[6:0]};
                if (!byte_in[7])
                begin
                    off_next   = '0;
                    phase_next = PH_OFFSET;
                end
            end
            PH_OFFSET:
            begin
                off_next = off_shift;
                if (!byte_in[7])
                begin
                    if (len_reg > 32'(MAX_RUN))
                    begin
                        cmd.kind = lzmd_pkg::CMD_ERR;
                    end
                    else if (len_reg != 32'd0)
                    begin
                        cmd.kind     = lzmd_pkg::CMD_COPY;
                        cmd.len      = len_reg[lzmd_pkg::LEN_W-1:0];
                        cmd.distance = off_shift;
                    end
                    phase_next = PH_SYMBOL;
                end
            end
            default:
            begin
                phase_next = PH_MARKER;
            end
        endcase
        if (last_byte)
        begin
            phase_next = PH_MARKER;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_MARKER;
            marker_reg <= 8'd0;
            len_reg    <= 32'd0;
            off_reg    <= '0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            marker_reg <= marker_next;
            len_reg    <= len_next;
            off_reg    <= off_next;
        end
    end

endmodule

FILE: rtl/lzmd_copy_engine.sv
module lzmd_copy_engine #(
    parameter int ADDR_W = 13
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [lzmd_pkg::WL_W-1:0]   wl,
    input  logic                        cmd_valid,
    input  lzmd_pkg::cmd_t              cmd,
    output logic                        cmd_ready,
    output logic                        wr_en,
    output logic [ADDR_W-1:0]           wr_addr,
    output logic [7:0]                  wr_data,
    output logic                        rd_en,
    output logic [ADDR_W-1:0]           rd_addr,
    input  logic [7:0]                  rd_data,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [7:0]                  m_tdata,
    output logic                        m_tlast,
    output logic                        m_tuser
);

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_READ,
        ST_EMIT
    } state_t;

    state_t                       state_reg, state_next;
    logic [lzmd_pkg::POS_W-1:0]   wp_reg, wp_next;
    logic [lzmd_pkg::POS_W-1:0]   dist_reg, dist_next;
    logic [lzmd_pkg::LEN_W-1:0]   cnt_reg, cnt_next;
    logic                         out_valid_reg, out_valid_next;
    logic [7:0]                   out_data_reg, out_data_next;
    logic                         out_last_reg, out_last_next;
    logic                         out_err_reg, out_err_next;

    logic                         out_free;
    logic                         out_load;
    logic [lzmd_pkg::POS_W-1:0]   mask;
    logic [lzmd_pkg::POS_W-1:0]   wr_slot;
    logic [lzmd_pkg::POS_W-1:0]   rd_slot;

    assign mask     = lzmd_pkg::slot_mask(wl);
    assign wr_slot  = wp_reg & mask;
    assign rd_slot  = (wp_reg - dist_reg) & mask;
    assign wr_addr  = wr_slot[ADDR_W-1:0];
    assign rd_addr  = rd_slot[ADDR_W-1:0];
    assign out_free = !out_valid_reg || m_tready;
    assign cmd_ready = (state_reg == ST_IDLE) && out_free;

    always_comb
    begin
        state_next    = state_reg;
        wp_next       = wp_reg;
        dist_next     = dist_reg;
        cnt_next      = cnt_reg;
        out_load      = 1'b0;
        out_data_next = out_data_reg;
        out_last_next = out_last_reg;
        out_err_next  = out_err_reg;
        wr_en         = 1'b0;
        wr_data       = cmd.lit;
        rd_en         = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    case (cmd.kind)
                        lzmd_pkg::CMD_LIT:
                        begin
                            wr_en         = 1'b1;
                            wp_next       = wp_reg + lzmd_pkg::POS_W'(1);
                            out_load      = 1'b1;
                            out_data_next = cmd.lit;
                            out_last_next = 1'b1;
                            out_err_next  = 1'b0;
                        end
                        lzmd_pkg::CMD_ERR:
                        begin
                            out_load      = 1'b1;
                            out_data_next = 8'd0;
                            out_last_next = 1'b1;
                            out_err_next  = 1'b1;
                        end
                        lzmd_pkg::CMD_COPY:
                        begin
                            cnt_next   = cmd.len;
                            dist_next  = cmd.distance;
                            state_next = ST_READ;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                rd_en      = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                // read data stays put while the output side stalls
                if (out_free)
                begin
                    wr_en         = 1'b1;
                    wr_data       = rd_data;
                    wp_next       = wp_reg + lzmd_pkg::POS_W'(1);
                    cnt_next      = cnt_reg - lzmd_pkg::LEN_W'(1);
                    out_load      = 1'b1;
                    out_data_next = rd_data;
                    out_last_next = (cnt_reg == lzmd_pkg::LEN_W'(1));
                    out_err_next  = 1'b0;
                    state_next    = (cnt_reg == lzmd_pkg::LEN_W'(1)) ? ST_IDLE : ST_READ;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wp_reg        <= '0;
            dist_reg      <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= 8'd0;
            out_last_reg  <= 1'b0;
            out_err_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wp_reg        <= wp_next;
            dist_reg      <= dist_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
            out_last_reg  <= out_last_next;
            out_err_reg   <= out_err_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_err_reg;

endmodule

FILE: rtl/lz77_marker_decompressor_unit.sv
// lz77 marker decompressor, one compressed byte per input word
// input stream: s_tdata carries the byte, s_tlast closes a stream; the first
// byte of each stream is taken as the marker
// output stream: one decompressed byte per word, m_tlast marks the final word
// caused by an input word, m_tuser flags an over-long match (data then 0)
// cfg_we/cfg_data set log2 of the history window in use; write it while idle
// an input word that produces a literal shows up on the output the cycle
// after it is taken; words that only advance the token parser produce no output
// a match copy goes through the window memory read-then-write: for each
// byte the engine reads the window in ST_READ, then in ST_EMIT writes the
// byte back at the write position and loads it into the output register;
// the next input word is taken only once the last copied byte is emitted
// the output register holds a word until taken; while the receiver stalls
// the copy waits and no new input is accepted
// reset returns the parser to awaiting a marker, clears the write position
// and sets the window log2 to 13; the window memory itself is not cleared
// WINDOW must be a power of two; the block itself does not enforce this
module lz77_marker_decompressor_unit #(
    parameter int WINDOW  = 8192,
    parameter int MAX_RUN = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,    // byte_in
    input  logic                        s_tlast,    // last_byte
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [7:0]                  m_tdata,    // data_out
    output logic                        m_tlast,    // run_end
    output logic                        m_tuser,    // length_error
    input  logic                        cfg_we,
    input  logic [lzmd_pkg::WL_W-1:0]   cfg_data
);

    localparam int ADDR_W = $clog2(WINDOW);

    logic [lzmd_pkg::WL_W-1:0]   wl_reg;
    logic                        accept;
    lzmd_pkg::cmd_t              cmd;
    logic                        wr_en;
    logic [ADDR_W-1:0]           wr_addr;
    logic [7:0]                  wr_data;
    logic                        rd_en;
    logic [ADDR_W-1:0]           rd_addr;
    logic [7:0]                  rd_data;

    assign accept = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wl_reg <= lzmd_pkg::WL_W'(13);
        end
        else if (cfg_we)
        begin
            wl_reg <= cfg_data;
        end
    end

    lzmd_token_parser #(
        .MAX_RUN   (MAX_RUN)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .byte_in   (s_tdata),
        .last_byte (s_tlast),
        .cmd       (cmd)
    );

    lzmd_copy_engine #(
        .ADDR_W    (ADDR_W)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .wl        (wl_reg),
        .cmd_valid (accept),
        .cmd       (cmd),
        .cmd_ready (s_tready),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    lzmd_window_ram #(
        .ADDR_W    (ADDR_W)
    ) u_window (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data)
    );

endmodule
